// ----- sv/sip_pkg.sv -----
// ---------------------------------------------------------------------------
// sip_pkg: shared types for the segment intersection point block
// Result kind codes and the control word that travels down the pipeline.
// ---------------------------------------------------------------------------
package sip_pkg;

    localparam int TOL_WIDTH  = 21;
    localparam int KIND_WIDTH = 3;

    // Result kind, in the order the endpoint cases are tried
    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_NONE  = 3'd0,
        KIND_CROSS = 3'd1,
        KIND_P2    = 3'd2,
        KIND_Q2    = 3'd3,
        KIND_P1    = 3'd4,
        KIND_Q1    = 3'd5
    } sip_kind_t;

    // Control word that rides alongside each request
    typedef struct packed {
        logic      valid;
        sip_kind_t kind;
        logic      neg_x;
        logic      neg_y;
        logic      ovf_x;
        logic      ovf_y;
    } sip_ctl_t;

endpackage

// ----- sv/segment_intersection_point.sv -----
// ---------------------------------------------------------------------------
// segment_intersection_point: 2D segment intersection with contact point
// Pipeline from request accept to result valid: five geometry stages,
// split multiply, dividend add, range check, one division cell per quotient
// bit and the output register.
// Throughput is one request per cycle; a stall holds the whole pipeline.
// Reset clears all valid bits and sets the tolerance register to 1.
// ---------------------------------------------------------------------------
module segment_intersection_point
    import sip_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // fields from bit 0: first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [8*COORD_WIDTH-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // fields from bit 0: contact_x, contact_y
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
    // fields from bit 0: hit, hit_kind
    output logic [KIND_WIDTH:0]        m_tuser,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [TOL_WIDTH-1:0]       cfg_data
);

    localparam int W    = COORD_WIDTH;
    localparam int DW   = W + 1;
    localparam int CW   = 2 * DW + 1;
    localparam int NL   = (CW + 1) / 2;
    localparam int NH   = CW - NL;
    localparam int DVW  = CW + DW;
    localparam int TOPW = DVW - W;
    localparam int MDW  = ((2 * W + 7) / 8) * 8;

    logic                 adv;
    logic [TOL_WIDTH-1:0] tol_reg;

    sip_ctl_t      g_ctl;
    logic [W-1:0]  g_bx, g_by;
    logic [CW-1:0] g_num, g_den;
    logic [DW-1:0] g_dxm, g_dym;

    sip_ctl_t         ctl1_reg, ctl2_reg, ctl3_reg;
    sip_ctl_t         ctl3_next;
    logic [W-1:0]     bx1_reg, by1_reg, bx2_reg, by2_reg;
    logic [CW-1:0]    den1_reg, den2_reg;
    logic [NH+DW-1:0] phx_reg, phy_reg;
    logic [NL+DW-1:0] plx_reg, ply_reg;
    logic [DVW-1:0]   dvx_reg, dvy_reg;

    sip_ctl_t      ctl_p [W+1];
    logic [W-1:0]  bx_p [W+1];
    logic [W-1:0]  by_p [W+1];
    logic [CW-1:0] remx_p [W+1];
    logic [CW-1:0] remy_p [W+1];
    logic [W-1:0]  lqx_p [W+1];
    logic [W-1:0]  lqy_p [W+1];
    logic [CW-1:0] denx_p [W+1];
    logic [CW-1:0] deny_p [W+1];

    logic              m_valid_reg;
    logic [W-1:0]      cx_next, cy_next, cx_reg, cy_reg;
    sip_kind_t         kind_out_reg;
    logic signed [W+1:0] sum_x, sum_y;

    // Pipeline moves when the output register is free or being drained
    assign adv       = !m_valid_reg || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    // Tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_WIDTH'(1);
        end
        else if (cfg_valid)
        begin
            tol_reg <= cfg_data;
        end
    end

    sip_geom #(
        .COORD_WIDTH (W)
    ) u_geom (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (s_tvalid),
        .in_coord (s_tdata),
        .tol      (tol_reg),
        .ctl      (g_ctl),
        .base_x   (g_bx),
        .base_y   (g_by),
        .num_mag  (g_num),
        .den_mag  (g_den),
        .dx_mag   (g_dxm),
        .dy_mag   (g_dym)
    );

    // Fold the quotient range check into the control word
    always_comb
    begin
        ctl3_next       = ctl2_reg;
        ctl3_next.ovf_x = dvx_reg[DVW-1:W] >= TOPW'(den2_reg);
        ctl3_next.ovf_y = dvy_reg[DVW-1:W] >= TOPW'(den2_reg);
    end

    // Advance the control words of the multiply, dividend add and range check stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else if (adv)
        begin
            ctl1_reg <= g_ctl;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl3_next;
        end
    end

    // Split multiply, dividend assembly and initial remainder
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            phx_reg   <= g_num[CW-1:NL] * g_dxm;
            plx_reg   <= g_num[NL-1:0] * g_dxm;
            phy_reg   <= g_num[CW-1:NL] * g_dym;
            ply_reg   <= g_num[NL-1:0] * g_dym;
            bx1_reg   <= g_bx;
            by1_reg   <= g_by;
            den1_reg  <= g_den;
            dvx_reg   <= {phx_reg, {NL{1'b0}}} + DVW'(plx_reg);
            dvy_reg   <= {phy_reg, {NL{1'b0}}} + DVW'(ply_reg);
            bx2_reg   <= bx1_reg;
            by2_reg   <= by1_reg;
            den2_reg  <= den1_reg;
            remx_p[0] <= dvx_reg[W+CW-1:W];
            remy_p[0] <= dvy_reg[W+CW-1:W];
            lqx_p[0]  <= dvx_reg[W-1:0];
            lqy_p[0]  <= dvy_reg[W-1:0];
            denx_p[0] <= den2_reg;
            deny_p[0] <= den2_reg;
            bx_p[0]   <= bx2_reg;
            by_p[0]   <= by2_reg;
        end
    end

    assign ctl_p[0] = ctl3_reg;

    // Division chain, one quotient bit per cell
    for (genvar i = 0; i < W; i++)
    begin : g_chain
        sip_div_cell #(
            .REM_WIDTH (CW),
            .Q_WIDTH   (W)
        ) u_cell_x (
            .clk      (clk),
            .adv      (adv),
            .rem_in   (remx_p[i]),
            .lowq_in  (lqx_p[i]),
            .den_in   (denx_p[i]),
            .rem_reg  (remx_p[i+1]),
            .lowq_reg (lqx_p[i+1]),
            .den_reg  (denx_p[i+1])
        );

        sip_div_cell #(
            .REM_WIDTH (CW),
            .Q_WIDTH   (W)
        ) u_cell_y (
            .clk      (clk),
            .adv      (adv),
            .rem_in   (remy_p[i]),
            .lowq_in  (lqy_p[i]),
            .den_in   (deny_p[i]),
            .rem_reg  (remy_p[i+1]),
            .lowq_reg (lqy_p[i+1]),
            .den_reg  (deny_p[i+1])
        );

        // Carry the control word and base point beside the cells
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_p[i+1] <= '0;
            end
            else if (adv)
            begin
                ctl_p[i+1] <= ctl_p[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                bx_p[i+1] <= bx_p[i];
                by_p[i+1] <= by_p[i];
            end
        end
    end

    // Apply the signed offset and saturate for a crossing; other kinds keep the base
    always_comb
    begin
        sum_x = ctl_p[W].neg_x
              ? {{2{bx_p[W][W-1]}}, bx_p[W]} - {2'b00, lqx_p[W]}
              : {{2{bx_p[W][W-1]}}, bx_p[W]} + {2'b00, lqx_p[W]};
        sum_y = ctl_p[W].neg_y
              ? {{2{by_p[W][W-1]}}, by_p[W]} - {2'b00, lqy_p[W]}
              : {{2{by_p[W][W-1]}}, by_p[W]} + {2'b00, lqy_p[W]};

        if (ctl_p[W].kind != KIND_CROSS)
            cx_next = bx_p[W];
        else if (ctl_p[W].ovf_x)
            cx_next = ctl_p[W].neg_x ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        else if (sum_x[W+1:W-1] != 3'b000 && sum_x[W+1:W-1] != 3'b111)
            cx_next = sum_x[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        else
            cx_next = sum_x[W-1:0];

        if (ctl_p[W].kind != KIND_CROSS)
            cy_next = by_p[W];
        else if (ctl_p[W].ovf_y)
            cy_next = ctl_p[W].neg_y ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        else if (sum_y[W+1:W-1] != 3'b000 && sum_y[W+1:W-1] != 3'b111)
            cy_next = sum_y[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        else
            cy_next = sum_y[W-1:0];
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg <= ctl_p[W].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg       <= cx_next;
            cy_reg       <= cy_next;
            kind_out_reg <= ctl_p[W].kind;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = MDW'({cy_reg, cx_reg});
    assign m_tuser  = {kind_out_reg, kind_out_reg != KIND_NONE};

    // Hit flag agrees with the kind code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[0] == (m_tuser[KIND_WIDTH:1] != KIND_NONE)))
        else $error("hit flag disagrees with hit kind");

    // A miss reports the origin
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("miss with nonzero contact point");

    // A request leaving the last cell lands in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_p[W].valid && adv) |=> m_tvalid)
        else $error("result lost at output register");

    // A stall freezes the end of the division chain
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(ctl_p[W]))
        else $error("division chain moved during stall");

endmodule

// ----- sv/sip_div_cell.sv -----
// ---------------------------------------------------------------------------
// sip_div_cell: one restoring division step
// Shifts one dividend bit into the partial remainder, subtracts the divisor
// when it fits and shifts the quotient bit in behind the remaining bits.
// ---------------------------------------------------------------------------
module sip_div_cell #(
    parameter int REM_WIDTH = 51,
    parameter int Q_WIDTH   = 24
) (
    input  logic                 clk,
    input  logic                 adv,
    input  logic [REM_WIDTH-1:0] rem_in,
    input  logic [Q_WIDTH-1:0]   lowq_in,
    input  logic [REM_WIDTH-1:0] den_in,
    output logic [REM_WIDTH-1:0] rem_reg,
    output logic [Q_WIDTH-1:0]   lowq_reg,
    output logic [REM_WIDTH-1:0] den_reg
);

    logic [REM_WIDTH:0]   trial;
    logic                 fits;
    logic [REM_WIDTH:0]   diff;
    logic [REM_WIDTH-1:0] rem_next;
    logic [Q_WIDTH-1:0]   lowq_next;

    // Compare and subtract
    always_comb
    begin
        trial     = {rem_in, lowq_in[Q_WIDTH-1]};
        fits      = trial >= {1'b0, den_in};
        diff      = trial - {1'b0, den_in};
        rem_next  = fits ? diff[REM_WIDTH-1:0] : trial[REM_WIDTH-1:0];
        lowq_next = {lowq_in[Q_WIDTH-2:0], fits};
    end

    // Hand the step result to the next cell
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg  <= rem_next;
            lowq_reg <= lowq_next;
            den_reg  <= den_in;
        end
    end

endmodule

// ----- sv/sip_geom.sv -----
// ---------------------------------------------------------------------------
// sip_geom: geometry front end
// Bounding box and endpoint range tests, orientation cross products,
// tolerance checks and case selection, five register stages.
// ---------------------------------------------------------------------------
module sip_geom
    import sip_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              in_valid,
    input  logic [8*COORD_WIDTH-1:0]          in_coord,
    input  logic [TOL_WIDTH-1:0]              tol,
    output sip_ctl_t                          ctl,
    output logic [COORD_WIDTH-1:0]            base_x,
    output logic [COORD_WIDTH-1:0]            base_y,
    output logic [2*COORD_WIDTH+2:0]          num_mag,
    output logic [2*COORD_WIDTH+2:0]          den_mag,
    output logic [COORD_WIDTH:0]              dx_mag,
    output logic [COORD_WIDTH:0]              dy_mag
);

    localparam int W     = COORD_WIDTH;
    localparam int DW    = W + 1;
    localparam int PW    = 2 * DW;
    localparam int CW    = PW + 1;
    localparam int CMP_W = (CW > TOL_WIDTH) ? CW : TOL_WIDTH;

    // Difference and product operand indexes
    localparam int D_E1X = 0;
    localparam int D_E1Y = 1;
    localparam int DIFF_A [14] = '{2, 3, 6, 7, 4, 5, 6, 7, 0, 1, 2, 3, 0, 1};
    localparam int DIFF_B [14] = '{0, 1, 4, 5, 2, 3, 2, 3, 6, 7, 6, 7, 4, 5};
    localparam int PROD_A [12] = '{1, 0, 1, 0, 3, 2, 3, 2, 0, 1, 13, 12};
    localparam int PROD_B [12] = '{4, 5, 6, 7, 8, 9, 10, 11, 3, 2, 2, 3};
    localparam int X_DEN  = 4;
    localparam int X_NUM  = 5;

    // Orientation codes
    localparam logic [1:0] ORI_ZERO = 2'd0;
    localparam logic [1:0] ORI_POS  = 2'd1;
    localparam logic [1:0] ORI_NEG  = 2'd2;

    function automatic logic signed [W-1:0] smin(logic signed [W-1:0] a,
                                                 logic signed [W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [W-1:0] smax(logic signed [W-1:0] a,
                                                 logic signed [W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic btw(logic signed [W-1:0] a, logic signed [W-1:0] c,
                                 logic signed [W-1:0] b);
        return (smin(a, b) <= c) && (c <= smax(a, b));
    endfunction

    logic [4:0] vld_reg;

    logic signed [W-1:0]  c1_reg [8];
    logic signed [W-1:0]  c2_reg [8];
    logic signed [W-1:0]  c3_reg [8];
    logic signed [W-1:0]  c4_reg [8];
    logic signed [DW-1:0] d2_next [14];
    logic signed [DW-1:0] d2_reg [14];
    logic signed [DW-1:0] e1x3_reg, e1y3_reg, e1x4_reg, e1y4_reg;
    logic signed [PW-1:0] p3_next [12];
    logic signed [PW-1:0] p3_reg [12];
    logic [CW-1:0]        x4_next [6];
    logic [CW-1:0]        x4_reg [6];
    logic                 bb2_next, bb2_reg, bb3_reg, bb4_reg;
    logic [3:0]           w2_next, w2_reg, w3_reg, w4_reg;

    logic [CW-1:0]  mag5 [6];
    logic [5:0]     small5;
    logic [1:0]     ori5 [4];
    logic           cross5;
    logic           den_bad5;
    sip_kind_t      kind_next, kind_reg;
    logic [W-1:0]   bx_next, by_next, bx_reg, by_reg;
    logic           negx_reg, negy_reg;
    logic [CW-1:0]  num_reg, den_reg;
    logic [DW-1:0]  dxm_reg, dym_reg;

    // Advance the stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    // Stage 2: differences, box overlap and endpoint range tests
    always_comb
    begin
        for (int i = 0; i < 14; i++)
        begin
            d2_next[i] = {c1_reg[DIFF_A[i]][W-1], c1_reg[DIFF_A[i]]}
                       - {c1_reg[DIFF_B[i]][W-1], c1_reg[DIFF_B[i]]};
        end
        bb2_next = !(smax(c1_reg[0], c1_reg[2]) < smin(c1_reg[4], c1_reg[6])
                  || smin(c1_reg[0], c1_reg[2]) > smax(c1_reg[4], c1_reg[6])
                  || smax(c1_reg[1], c1_reg[3]) < smin(c1_reg[5], c1_reg[7])
                  || smin(c1_reg[1], c1_reg[3]) > smax(c1_reg[5], c1_reg[7]));
        w2_next[0] = btw(c1_reg[0], c1_reg[4], c1_reg[2])
                  && btw(c1_reg[1], c1_reg[5], c1_reg[3]);
        w2_next[1] = btw(c1_reg[0], c1_reg[6], c1_reg[2])
                  && btw(c1_reg[1], c1_reg[7], c1_reg[3]);
        w2_next[2] = btw(c1_reg[4], c1_reg[0], c1_reg[6])
                  && btw(c1_reg[5], c1_reg[1], c1_reg[7]);
        w2_next[3] = btw(c1_reg[4], c1_reg[2], c1_reg[6])
                  && btw(c1_reg[5], c1_reg[3], c1_reg[7]);
    end

    // Stage 3: products
    always_comb
    begin
        for (int i = 0; i < 12; i++)
        begin
            p3_next[i] = d2_reg[PROD_A[i]] * d2_reg[PROD_B[i]];
        end
    end

    // Stage 4: cross products
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            x4_next[i] = {p3_reg[2*i][PW-1], p3_reg[2*i]}
                       - {p3_reg[2*i+1][PW-1], p3_reg[2*i+1]};
        end
    end

    // Stage 5: tolerance checks, orientations and case selection
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            mag5[i]   = x4_reg[i][CW-1] ? (~x4_reg[i] + 1'b1) : x4_reg[i];
            small5[i] = CMP_W'(mag5[i]) < CMP_W'(tol);
        end
        for (int i = 0; i < 4; i++)
        begin
            if (small5[i])
                ori5[i] = ORI_ZERO;
            else if (!x4_reg[i][CW-1] && x4_reg[i] != '0)
                ori5[i] = ORI_POS;
            else
                ori5[i] = ORI_NEG;
        end
        cross5   = (ori5[0] != ori5[1]) && (ori5[2] != ori5[3]);
        den_bad5 = (x4_reg[X_DEN] == '0) || small5[X_DEN];

        priority if (!bb4_reg)
            kind_next = KIND_NONE;
        else if (cross5)
            kind_next = den_bad5 ? KIND_NONE : KIND_CROSS;
        else if (ori5[0] == ORI_ZERO && w4_reg[0])
            kind_next = KIND_P2;
        else if (ori5[1] == ORI_ZERO && w4_reg[1])
            kind_next = KIND_Q2;
        else if (ori5[2] == ORI_ZERO && w4_reg[2])
            kind_next = KIND_P1;
        else if (ori5[3] == ORI_ZERO && w4_reg[3])
            kind_next = KIND_Q1;
        else
            kind_next = KIND_NONE;

        unique case (kind_next)
            KIND_CROSS, KIND_P1:
            begin
                bx_next = c4_reg[0];
                by_next = c4_reg[1];
            end
            KIND_P2:
            begin
                bx_next = c4_reg[4];
                by_next = c4_reg[5];
            end
            KIND_Q2:
            begin
                bx_next = c4_reg[6];
                by_next = c4_reg[7];
            end
            KIND_Q1:
            begin
                bx_next = c4_reg[2];
                by_next = c4_reg[3];
            end
            default:
            begin
                bx_next = '0;
                by_next = '0;
            end
        endcase
    end

    // Hold the payload of every stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 8; i++)
            begin
                c1_reg[i] <= in_coord[i*W +: W];
                c2_reg[i] <= c1_reg[i];
                c3_reg[i] <= c2_reg[i];
                c4_reg[i] <= c3_reg[i];
            end
            d2_reg   <= d2_next;
            bb2_reg  <= bb2_next;
            w2_reg   <= w2_next;
            p3_reg   <= p3_next;
            e1x3_reg <= d2_reg[D_E1X];
            e1y3_reg <= d2_reg[D_E1Y];
            bb3_reg  <= bb2_reg;
            w3_reg   <= w2_reg;
            x4_reg   <= x4_next;
            e1x4_reg <= e1x3_reg;
            e1y4_reg <= e1y3_reg;
            bb4_reg  <= bb3_reg;
            w4_reg   <= w3_reg;
            kind_reg <= kind_next;
            bx_reg   <= bx_next;
            by_reg   <= by_next;
            negx_reg <= x4_reg[X_NUM][CW-1] ^ e1x4_reg[DW-1] ^ x4_reg[X_DEN][CW-1];
            negy_reg <= x4_reg[X_NUM][CW-1] ^ e1y4_reg[DW-1] ^ x4_reg[X_DEN][CW-1];
            num_reg  <= mag5[X_NUM];
            den_reg  <= mag5[X_DEN];
            dxm_reg  <= e1x4_reg[DW-1] ? (~e1x4_reg + 1'b1) : e1x4_reg;
            dym_reg  <= e1y4_reg[DW-1] ? (~e1y4_reg + 1'b1) : e1y4_reg;
        end
    end

    assign ctl.valid = vld_reg[4];
    assign ctl.kind  = kind_reg;
    assign ctl.neg_x = negx_reg;
    assign ctl.neg_y = negy_reg;
    assign ctl.ovf_x = 1'b0;
    assign ctl.ovf_y = 1'b0;
    assign base_x    = bx_reg;
    assign base_y    = by_reg;
    assign num_mag   = num_reg;
    assign den_mag   = den_reg;
    assign dx_mag    = dxm_reg;
    assign dy_mag    = dym_reg;

endmodule

// ----- tb/segment_intersection_point_checker.sv -----
// ---------------------------------------------------------------------------
// segment_intersection_point_checker: result predictor and scoreboard
// Watches the request, result and tolerance channels at the rising edge,
// computes the expected contact for each accepted segment pair and compares
// every result field against the oldest pending prediction.
// ---------------------------------------------------------------------------
module segment_intersection_point_checker
    import sip_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [8*COORD_WIDTH-1:0]            s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]  m_tdata,
    input  logic [KIND_WIDTH:0]                 m_tuser,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [TOL_WIDTH-1:0]                cfg_data,
    output int                                  fail_count,
    output int                                  pending_count,
    output int                                  result_count,
    output int                                  cross_count,
    output int                                  touch_count
);

    typedef struct {
        logic                   hit;
        logic [COORD_WIDTH-1:0] cx;
        logic [COORD_WIDTH-1:0] cy;
        sip_kind_t              kind;
    } contact_t;

    contact_t       contact_q[$];
    longint         tolerance;

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic bit near_zero(longint v);
        return mag(v) < tolerance;
    endfunction

    function automatic int side(longint ax, longint ay, longint bx, longint by,
                                longint px, longint py);
        longint v;
        v = (by - ay) * (px - bx) - (bx - ax) * (py - by);
        if (near_zero(v)) return 0;
        return (v > 0) ? 1 : 2;
    endfunction

    function automatic bit on_box(longint ax, longint ay, longint px, longint py,
                                  longint bx, longint by);
        return ((ax < bx ? ax : bx) <= px) && (px <= (ax > bx ? ax : bx)) &&
               ((ay < by ? ay : by) <= py) && (py <= (ay > by ? ay : by));
    endfunction

    // base + trunc(num*d/den), quotient capped at 2^40, then saturated
    function automatic longint lerp_sat(longint base, longint num, longint d,
                                        longint den);
        logic signed [127:0] prod;
        logic [127:0]        qm;
        longint              q, r, lim;
        bit                  neg;
        prod = $signed(128'(num)) * $signed(128'(d));
        neg  = (prod < 0) != (den < 0);
        qm   = ((prod < 0) ? -prod : prod) / 128'(mag(den));
        q    = (qm > (128'd1 << 40)) ? (longint'(1) << 40) : longint'(qm);
        r    = neg ? base - q : base + q;
        lim  = longint'(1) << (COORD_WIDTH - 1);
        if (r > lim - 1) r = lim - 1;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic contact_t predict_contact(logic [8*COORD_WIDTH-1:0] pair);
        longint   c[8];
        longint   p1x, p1y, q1x, q1y, p2x, p2y, q2x, q2y, den, num;
        int       o1, o2, o3, o4;
        contact_t res;
        for (int i = 0; i < 8; i++)
        begin
            c[i] = longint'($signed(pair[i*COORD_WIDTH +: COORD_WIDTH]));
        end
        p1x = c[0]; p1y = c[1]; q1x = c[2]; q1y = c[3];
        p2x = c[4]; p2y = c[5]; q2x = c[6]; q2y = c[7];
        res = '{1'b0, '0, '0, KIND_NONE};
        // reject on disjoint bounding boxes
        if ((p1x > q1x ? p1x : q1x) < (p2x < q2x ? p2x : q2x) ||
            (p1x < q1x ? p1x : q1x) > (p2x > q2x ? p2x : q2x) ||
            (p1y > q1y ? p1y : q1y) < (p2y < q2y ? p2y : q2y) ||
            (p1y < q1y ? p1y : q1y) > (p2y > q2y ? p2y : q2y))
            return res;
        o1 = side(p1x, p1y, q1x, q1y, p2x, p2y);
        o2 = side(p1x, p1y, q1x, q1y, q2x, q2y);
        o3 = side(p2x, p2y, q2x, q2y, p1x, p1y);
        o4 = side(p2x, p2y, q2x, q2y, q1x, q1y);
        if (o1 != o2 && o3 != o4)
        begin
            den = (p1x - q1x) * (p2y - q2y) - (p1y - q1y) * (p2x - q2x);
            if (den == 0 || near_zero(den)) return res;
            num = (p1x - p2x) * (p2y - q2y) - (p1y - p2y) * (p2x - q2x);
            res.cx   = COORD_WIDTH'(lerp_sat(p1x, num, q1x - p1x, den));
            res.cy   = COORD_WIDTH'(lerp_sat(p1y, num, q1y - p1y, den));
            res.kind = KIND_CROSS;
        end
        else if (o1 == 0 && on_box(p1x, p1y, p2x, p2y, q1x, q1y))
        begin
            res.cx = COORD_WIDTH'(p2x); res.cy = COORD_WIDTH'(p2y); res.kind = KIND_P2;
        end
        else if (o2 == 0 && on_box(p1x, p1y, q2x, q2y, q1x, q1y))
        begin
            res.cx = COORD_WIDTH'(q2x); res.cy = COORD_WIDTH'(q2y); res.kind = KIND_Q2;
        end
        else if (o3 == 0 && on_box(p2x, p2y, p1x, p1y, q2x, q2y))
        begin
            res.cx = COORD_WIDTH'(p1x); res.cy = COORD_WIDTH'(p1y); res.kind = KIND_P1;
        end
        else if (o4 == 0 && on_box(p2x, p2y, q1x, q1y, q2x, q2y))
        begin
            res.cx = COORD_WIDTH'(q1x); res.cy = COORD_WIDTH'(q1y); res.kind = KIND_Q1;
        end
        res.hit = (res.kind != KIND_NONE);
        return res;
    endfunction

    assign pending_count = contact_q.size();

    // track tolerance, queue predictions, compare results
    always @(posedge clk or negedge rst_n)
    begin
        contact_t exp_c;
        if (!rst_n)
        begin
            tolerance    = 1;
            fail_count   <= 0;
            result_count <= 0;
            cross_count  <= 0;
            touch_count  <= 0;
            contact_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                tolerance = longint'(cfg_data);
            if (s_tvalid && s_tready)
                contact_q.insert(contact_q.size(), predict_contact(s_tdata));
            if (m_tvalid && m_tready)
            begin
                result_count <= result_count + 1;
                if (contact_q.size() == 0)
                begin
                    $error("result with no request pending");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_c = contact_q.pop_front();
                    if (exp_c.kind == KIND_CROSS) cross_count <= cross_count + 1;
                    else if (exp_c.hit) touch_count <= touch_count + 1;
                    if (m_tuser[0] !== exp_c.hit ||
                        m_tuser[KIND_WIDTH:1] !== exp_c.kind ||
                        m_tdata[0 +: COORD_WIDTH] !== exp_c.cx ||
                        m_tdata[COORD_WIDTH +: COORD_WIDTH] !== exp_c.cy)
                        fail_count <= fail_count + 1;
                    if (m_tuser[0] !== exp_c.hit)
                        $error("hit: expected %0d, got %0d", exp_c.hit, m_tuser[0]);
                    if (m_tuser[KIND_WIDTH:1] !== exp_c.kind)
                        $error("hit_kind: expected %0d, got %0d", exp_c.kind,
                               m_tuser[KIND_WIDTH:1]);
                    if (m_tdata[0 +: COORD_WIDTH] !== exp_c.cx)
                        $error("contact_x: expected %h, got %h", exp_c.cx,
                               m_tdata[0 +: COORD_WIDTH]);
                    if (m_tdata[COORD_WIDTH +: COORD_WIDTH] !== exp_c.cy)
                        $error("contact_y: expected %h, got %h", exp_c.cy,
                               m_tdata[COORD_WIDTH +: COORD_WIDTH]);
                end
            end
        end
    end

endmodule

// ----- tb/segment_intersection_point_tb.sv -----
// ---------------------------------------------------------------------------
// segment_intersection_point_tb: stimulus and verdict
// Drives directed and random segment pairs across several tolerance settings
// and idle patterns; the checker beside the block scores every result.
// ---------------------------------------------------------------------------
module segment_intersection_point_tb
    import sip_pkg::*;
();

    localparam int CW      = 24;
    localparam int LAT     = 9 + CW;
    localparam int STALL_LIMIT = 20000;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [8*CW-1:0]                s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [((2*CW+7)/8)*8-1:0]      m_tdata;
    logic [KIND_WIDTH:0]            m_tuser;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [TOL_WIDTH-1:0]           cfg_data;
    int                             fail_count, pending_count, result_count;
    int                             cross_count, touch_count;
    int                             send_idle, recv_stall;
    int                             quiet_cycles;
    bit                             timed_out;

    segment_intersection_point #(.COORD_WIDTH(CW)) dut (.*);

    segment_intersection_point_checker #(.COORD_WIDTH(CW)) u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // randomly stall the result side
    always @(negedge clk)
    begin
        m_tready <= !($urandom_range(99) < recv_stall);
    end

    // watchdog: count cycles with no accepted request or result
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("segment_intersection_point_tb: done, errors");
            $finish;
        end
    end

    function automatic logic [CW-1:0] rand_coord(int scale);
        case (scale)
            0: return CW'($signed($urandom_range(64)) - 32);
            1: return CW'($signed($urandom_range(1 << 16)) - (1 << 15));
            default: return CW'($urandom);
        endcase
    endfunction

    // hold the request until accepted; the next call or caller drops valid
    task automatic send_pair(logic [CW-1:0] c[8]);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c[7], c[6], c[5], c[4], c[3], c[2], c[1], c[0]};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_tolerance(logic [TOL_WIDTH-1:0] tol);
        s_tvalid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (LAT + 4) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= tol;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // crossing, touching, collinear or unshaped pair with random content
    task automatic send_shaped(int scale);
        logic [CW-1:0] c[8];
        int            t;
        for (int i = 0; i < 8; i++)
            c[i] = rand_coord(scale);
        t = $urandom_range(5);
        case (t)
            0: begin c[4] = c[0]; c[5] = c[1]; end
            1: begin c[6] = c[2]; c[7] = c[3]; end
            2: begin c[4] = c[2]; c[5] = c[3]; end
            3:
            begin
                // collinear: shift the first segment along itself
                c[4] = c[0] + (c[2] - c[0]) / 2; c[5] = c[1] + (c[3] - c[1]) / 2;
                c[6] = c[2] + (c[2] - c[0]) / 2; c[7] = c[3] + (c[3] - c[1]) / 2;
            end
            4:
            begin
                // mirror so the segments cross
                c[4] = c[0]; c[5] = c[3]; c[6] = c[2]; c[7] = c[1];
            end
            default: ;
        endcase
        send_pair(c);
    endtask

    task automatic send_directed();
        logic [CW-1:0] c[8];
        logic [CW-1:0] mx, mnv;
        mx  = {1'b0, {(CW-1){1'b1}}};
        mnv = {1'b1, {(CW-1){1'b0}}};
        // plain X crossing
        c = '{0, 0, 4096, 4096, 0, 4096, 4096, 0};                  send_pair(c);
        // disjoint boxes
        c = '{0, 0, 10, 10, 100, 100, 200, 200};                    send_pair(c);
        // a T-junction at each endpoint in turn; these report as crossings
        c = '{0, 0, 100, 0, 50, 0, 50, 80};                         send_pair(c);
        c = '{0, 0, 100, 0, 50, 80, 50, 0};                         send_pair(c);
        c = '{50, 0, 50, 80, 0, 0, 100, 0};                         send_pair(c);
        c = '{50, 80, 50, 0, 0, 0, 100, 0};                         send_pair(c);
        // collinear overlap and parallel offset
        c = '{0, 0, 100, 100, 50, 50, 150, 150};                    send_pair(c);
        c = '{0, 0, 100, 100, 0, 1, 100, 101};                      send_pair(c);
        // full-range extremes
        c = '{mnv, mnv, mx, mx, mnv, mx, mx, mnv};                  send_pair(c);
        c = '{mx, mx, mx, mx, mx, mx, mx, mx};                      send_pair(c);
        c = '{mnv, mnv, mnv, mnv, mnv, mnv, mnv, mnv};              send_pair(c);
        c = '{mnv, 0, mx, 0, 0, mnv, 0, mx};                        send_pair(c);
        c = '{-1, -1, 1, 1, -1, 1, 1, -1};                          send_pair(c);
        // near-parallel crossing with small denominator
        c = '{0, 0, 1000, 1, 0, 1, 1000, 0};                        send_pair(c);
        c = '{mnv, mnv, mx, mx, mnv, mnv + 1, mx, mx - 1};          send_pair(c);
    endtask

    initial
    begin
        logic [CW-1:0] c[8];
        int            phase;
        int            tols[6];
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        send_idle    = 0;
        recv_stall   = 0;
        quiet_cycles = 0;
        timed_out    = 1'b0;
        tols = '{1, 0, 1048576, 4096, 2097151, 1 << 12};
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_directed();
        // walk tolerance settings and idle patterns
        for (phase = 0; phase < 6; phase++)
        begin
            set_tolerance(TOL_WIDTH'(tols[phase]));
            case (phase % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 49; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 49; end
                default: begin send_idle = 12; recv_stall = 12; end
            endcase
            if (phase == 1 || phase == 4)
                send_directed();
            for (int n = 0; n < 270; n++)
            begin
                if ($urandom_range(99) < 75)
                    send_shaped($urandom_range(99) < 10 ? 2 : $urandom_range(1));
                else
                begin
                    for (int i = 0; i < 8; i++)
                        c[i] = rand_coord($urandom_range(2));
                    send_pair(c);
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (LAT + 4) @(negedge clk);
        $display("covered %0d results: %0d crossings, %0d endpoint touches",
                 result_count, cross_count, touch_count);
        $display("tolerance settings 0 through 2097151, with sender and receiver idling");
        if (fail_count == 0)
            $display("segment_intersection_point_tb: done, clean");
        else
            $display("segment_intersection_point_tb: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
sv/sip_pkg.sv
sv/sip_div_cell.sv
sv/sip_geom.sv
sv/segment_intersection_point.sv
tb/segment_intersection_point_checker.sv
tb/segment_intersection_point_tb.sv
